// ----- sv/brb_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the ring buffer.
package brb_pkg;

  localparam int RING_AW     = 16;
  localparam int RING_DEPTH  = 1 << RING_AW;
  localparam int POS_W       = 40;
  localparam int MR_W        = 7;
  localparam int MAX_RESULTS = 64;
  localparam int FIFO_AW     = 2;
  localparam int FIFO_DEPTH  = 1 << FIFO_AW;
  localparam int FIFO_CW     = FIFO_AW + 1;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic REG_MAX_READ = 1'b0;

  localparam logic [MR_W-1:0] MAX_READ_RST = MR_W'(MAX_RESULTS);

  typedef struct packed {
    logic store_wr;
    logic load_rd;
    logic load_cnt;
    logic issue_byte;
    logic issue_nd;
  } brb_cmd_t;

  typedef struct packed {
    logic caught;
    logic space;
    logic final_byte;
  } brb_sts_t;

endpackage

// ----- sv/brb_ctrl.sv -----
// Controller state machine: sequences writes, read setup and byte streaming.
module brb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_command,
  input  brb_pkg::brb_sts_t sts,
  output brb_pkg::brb_cmd_t cmd
);
  import brb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_STREAM
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_command == CMD_WRITE) begin
            cmd.store_wr = 1'b1;
          end else begin
            cmd.load_rd = 1'b1;
            state_nxt   = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        if (sts.caught) begin
          if (sts.space) begin
            cmd.issue_nd = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end else begin
          cmd.load_cnt = 1'b1;
          state_nxt    = ST_STREAM;
        end
      end
      ST_STREAM: begin
        if (sts.space) begin
          cmd.issue_byte = 1'b1;
          if (sts.final_byte) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- sv/brb_datapath.sv -----
// Datapath: byte ring memory, write count, read window arithmetic and result queue.
module brb_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  brb_pkg::brb_cmd_t               cmd,
  output brb_pkg::brb_sts_t               sts,
  input  logic [7:0]                      in_write_byte,
  input  logic [brb_pkg::POS_W-1:0]       in_read_offset,
  input  logic                            cfg_we,
  input  logic [brb_pkg::MR_W-1:0]        cfg_wdata,
  output logic [brb_pkg::MR_W-1:0]        max_read,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_byte,
  output logic [brb_pkg::POS_W-1:0]       out_position,
  output logic [brb_pkg::POS_W-1:0]       out_next_offset,
  output logic                            out_no_data,
  output logic                            out_last
);
  import brb_pkg::*;

  localparam logic [POS_W-1:0] CNT_MAX = '1;

  logic [7:0]       mem [RING_DEPTH];
  logic [7:0]       mem_q_r;

  logic [POS_W-1:0] wc_r, wc_nxt;
  logic [POS_W-1:0] early_r, early_nxt;
  logic [MR_W-1:0]  max_read_r, max_read_nxt;
  logic [POS_W-1:0] off_r, off_nxt;
  logic             caught_r, caught_nxt;
  logic [MR_W-1:0]  rem_r, rem_nxt;
  logic             wr_go;

  logic             p_vld_r;
  logic [POS_W-1:0] p_pos_r;
  logic             p_nd_r;
  logic             p_last_r;

  logic [7:0]       f_byte [FIFO_DEPTH];
  logic [POS_W-1:0] f_pos  [FIFO_DEPTH];
  logic [POS_W-1:0] f_next [FIFO_DEPTH];
  logic             f_nd   [FIFO_DEPTH];
  logic             f_last [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_r, rptr_r;
  logic [FIFO_CW-1:0] fcnt_r, fcnt_nxt;
  logic             push, pop;

  logic [MR_W-1:0]  lim;
  logic [POS_W-1:0] avail;
  logic             issue;

  assign issue = cmd.issue_byte | cmd.issue_nd;
  assign wr_go = cmd.store_wr && (wc_r != CNT_MAX);

  // Effective read limit: zero acts as one, clip at the result cap.
  always_comb begin
    if (max_read_r == '0) begin
      lim = MR_W'(1);
    end else if (max_read_r > MR_W'(MAX_RESULTS)) begin
      lim = MR_W'(MAX_RESULTS);
    end else begin
      lim = max_read_r;
    end
  end

  assign avail = wc_r - off_r;

  always_comb begin
    wc_nxt       = wc_r;
    early_nxt    = early_r;
    max_read_nxt = max_read_r;
    off_nxt      = off_r;
    caught_nxt   = caught_r;
    rem_nxt      = rem_r;
    if (cfg_we) begin
      max_read_nxt = cfg_wdata;
    end
    if (wr_go) begin
      wc_nxt = wc_r + POS_W'(1);
      // Oldest retained byte moves once the ring has wrapped.
      if (|wc_r[POS_W-1:RING_AW]) begin
        early_nxt = early_r + POS_W'(1);
      end
    end
    if (cmd.load_rd) begin
      caught_nxt = (in_read_offset >= wc_r);
      off_nxt    = (in_read_offset < early_r) ? early_r : in_read_offset;
    end
    if (cmd.load_cnt) begin
      rem_nxt = (avail > POS_W'(lim)) ? lim : avail[MR_W-1:0];
    end
    if (cmd.issue_byte) begin
      off_nxt = off_r + POS_W'(1);
      rem_nxt = rem_r - MR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r       <= '0;
      early_r    <= '0;
      max_read_r <= MAX_READ_RST;
      caught_r   <= 1'b0;
      rem_r      <= '0;
      p_vld_r    <= 1'b0;
    end else begin
      wc_r       <= wc_nxt;
      early_r    <= early_nxt;
      max_read_r <= max_read_nxt;
      caught_r   <= caught_nxt;
      rem_r      <= rem_nxt;
      p_vld_r    <= issue;
    end
  end

  always_ff @(posedge clk) begin
    off_r <= off_nxt;
    if (issue) begin
      p_pos_r  <= off_r;
      p_nd_r   <= cmd.issue_nd;
      p_last_r <= cmd.issue_nd || (rem_r == MR_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (wr_go) begin
      mem[wc_r[RING_AW-1:0]] <= in_write_byte;
    end
    if (cmd.issue_byte) begin
      mem_q_r <= mem[off_r[RING_AW-1:0]];
    end
  end

  // Result queue after the memory read stage.
  assign push = p_vld_r;
  assign pop  = out_valid && out_ready;

  always_comb begin
    fcnt_nxt = fcnt_r;
    if (push && !pop) begin
      fcnt_nxt = fcnt_r + FIFO_CW'(1);
    end else if (pop && !push) begin
      fcnt_nxt = fcnt_r - FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fcnt_r <= '0;
    end else begin
      fcnt_r <= fcnt_nxt;
      if (push) begin
        wptr_r <= wptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + FIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      f_byte[wptr_r] <= p_nd_r ? 8'd0 : mem_q_r;
      f_pos[wptr_r]  <= p_pos_r;
      f_next[wptr_r] <= p_nd_r ? p_pos_r : p_pos_r + POS_W'(1);
      f_nd[wptr_r]   <= p_nd_r;
      f_last[wptr_r] <= p_last_r;
    end
  end

  assign out_valid       = (fcnt_r != '0);
  assign out_byte        = f_byte[rptr_r];
  assign out_position    = f_pos[rptr_r];
  assign out_next_offset = f_next[rptr_r];
  assign out_no_data     = f_nd[rptr_r];
  assign out_last        = f_last[rptr_r];

  assign max_read = max_read_r;

  assign sts.caught     = caught_r;
  assign sts.space      = ((FIFO_CW+1)'(fcnt_r) + (FIFO_CW+1)'(p_vld_r))
                          < (FIFO_CW+1)'(FIFO_DEPTH);
  assign sts.final_byte = (rem_r == MR_W'(1));

endmodule

// ----- sv/broadcast_byte_ring_buffer.sv -----
// Top level of the broadcast byte ring buffer: register port, controller and datapath.
//
// Input channel (in_valid/in_ready): each item is a write (in_command 0) that
// appends in_write_byte to a 64 KiB ring at the absolute write count, or a read
// (in_command 1) that asks for bytes starting at absolute position in_read_offset.
// A write gives no result; writes stream at one per cycle.
// Once the 40-bit count saturates, further writes are dropped.
// A read sets up in two steps (offset clamp, then length) and then issues one
// ring read per cycle while the result queue has space; each byte result passes
// the ring read register and then the result queue. The input is held off until
// the last ring read has issued. A caught-up reader gets a single no_data result
// echoing its offset.
// Result channel (out_valid/out_ready): a four-entry result queue decouples the
// ring read stage from the receiver; when the receiver stalls the queue fills
// and byte reads pause, nothing is lost or repeated.
// Register max_read (byte address 0, reset 64) caps the bytes per read; write it
// only while the block is idle. Reset clears the count and the queue; the ring
// contents stay undefined, but only positions written since reset are ever read.
module broadcast_byte_ring_buffer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_command,
  input  logic [7:0]                      in_write_byte,
  input  logic [brb_pkg::POS_W-1:0]       in_read_offset,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_byte,
  output logic [brb_pkg::POS_W-1:0]       out_position,
  output logic [brb_pkg::POS_W-1:0]       out_next_offset,
  output logic                            out_no_data,
  output logic                            out_last,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [brb_pkg::PADDR_W-1:0]     paddr,
  input  logic [brb_pkg::PDATA_W-1:0]     pwdata,
  output logic [brb_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);
  import brb_pkg::*;

  brb_cmd_t        cmd;
  brb_sts_t        sts;
  logic            cfg_we;
  logic [MR_W-1:0] max_read;

  // Register port: zero wait states, word index in paddr[2].
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_MAX_READ);

  always_comb begin
    if (paddr[2] == REG_MAX_READ) begin
      prdata = PDATA_W'(max_read);
    end else begin
      prdata = '0;
    end
  end

  brb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .sts        (sts),
    .cmd        (cmd)
  );

  brb_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_write_byte   (in_write_byte),
    .in_read_offset  (in_read_offset),
    .cfg_we          (cfg_we),
    .cfg_wdata       (pwdata[MR_W-1:0]),
    .max_read        (max_read),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_position    (out_position),
    .out_next_offset (out_next_offset),
    .out_no_data     (out_no_data),
    .out_last        (out_last)
  );

endmodule

// ----- test/broadcast_byte_ring_buffer_test.sv -----
// Self-checking testbench for broadcast_byte_ring_buffer: ring predictor, stimulus and checks.
module broadcast_byte_ring_buffer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import brb_pkg::*;

  // Wait after the last result before touching the register or ending the run.
  localparam int SETTLE_CYCLES = 8;
  // Receiver hold-off used to back the block up into its input.
  localparam int LONG_HOLD = 300;
  // Read limits visited by the random phases; a final phase picks one at random.
  localparam logic [MR_W-1:0] LIMIT_STEPS [5] = '{
    MR_W'(33), MR_W'(0), MR_W'(64), MR_W'(1), MR_W'(127)
  };

  typedef struct packed {
    logic [7:0]       data;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] next_offset;
    logic             no_data;
    logic             last;
  } ring_result_t;

  // Mirror of the ring and its write count; queues the bytes each read should return.
  class ring_read_tracker;
    logic [7:0]       ring_copy [RING_DEPTH];
    logic [POS_W-1:0] bytes_written;
    logic [MR_W-1:0]  max_read;
    ring_result_t     pending_reads [$];
    int               errors;

    function void reset_state();
      bytes_written = '0;
      max_read      = MAX_READ_RST;
      errors        = 0;
      pending_reads.delete();
    endfunction

    function void note_item(logic command, logic [7:0] wr_byte, logic [POS_W-1:0] offset);
      logic [POS_W-1:0] oldest, start, count, pos;
      int               limit;
      ring_result_t     r;
      if (command == CMD_WRITE) begin
        // Drop writes once the count has saturated.
        if (bytes_written != '1) begin
          ring_copy[bytes_written[RING_AW-1:0]] = wr_byte;
          bytes_written++;
        end
        return;
      end
      if (offset >= bytes_written) begin
        r = '{data: 8'h00, position: offset, next_offset: offset, no_data: 1'b1, last: 1'b1};
        pending_reads = {pending_reads, r};
        return;
      end
      // Move a stale offset up to the oldest byte still in the ring.
      oldest = (bytes_written > POS_W'(RING_DEPTH)) ? bytes_written - POS_W'(RING_DEPTH) : '0;
      start  = (offset < oldest) ? oldest : offset;
      limit  = (max_read == 0) ? 1 : (max_read > MAX_RESULTS) ? MAX_RESULTS : int'(max_read);
      count  = bytes_written - start;
      if (count > POS_W'(limit)) count = POS_W'(limit);
      for (int i = 0; i < count; i++) begin
        pos           = start + POS_W'(i);
        r.data        = ring_copy[pos[RING_AW-1:0]];
        r.position    = pos;
        r.next_offset = pos + POS_W'(1);
        r.no_data     = 1'b0;
        r.last        = (i == count - 1);
        pending_reads = {pending_reads, r};
      end
    endfunction

    function void compare_field(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(ring_result_t got);
      ring_result_t want;
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h %h %h %b %b",
                 $time, got.data, got.position, got.next_offset, got.no_data, got.last);
        errors++;
        return;
      end
      want = pending_reads.pop_front();
      compare_field("out_byte", POS_W'(want.data), POS_W'(got.data));
      compare_field("out_position", want.position, got.position);
      compare_field("out_next_offset", want.next_offset, got.next_offset);
      compare_field("out_no_data", POS_W'(want.no_data), POS_W'(got.no_data));
      compare_field("out_last", POS_W'(want.last), POS_W'(got.last));
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic             in_command;
  logic [7:0]       in_write_byte;
  logic [POS_W-1:0] in_read_offset;
  logic             out_valid;
  logic             out_ready;
  logic [7:0]       out_byte;
  logic [POS_W-1:0] out_position;
  logic [POS_W-1:0] out_next_offset;
  logic             out_no_data;
  logic             out_last;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic             pready;

  // Random idling on both channels; cleared for the last part of the run.
  bit gaps_on = 1'b1;
  // Cycles the receiver must hold off; picked up by the receiver process.
  int sink_hold = 0;

  ring_read_tracker tracker = new();

  broadcast_byte_ring_buffer dut (.*);

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Offer one item, optionally after an idle burst, and hold it until accepted.
  // Valid stays high on return so back-to-back items stream without a bubble.
  task automatic send_item(logic command, logic [7:0] wr_byte, logic [POS_W-1:0] offset);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= command;
    in_write_byte  <= wr_byte;
    in_read_offset <= offset;
    do @(posedge clk); while (!in_ready);
    tracker.note_item(command, wr_byte, offset);
  endtask

  // Stop offering items and wait until every queued result has come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write max_read over the register port once the block is idle.
  task automatic write_max_read(logic [MR_W-1:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({REG_MAX_READ, 2'b00});
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.max_read = value;
  endtask

  // Check every result taken by the receiver against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_result(ring_result_t'{data: out_byte, position: out_position,
                                          next_offset: out_next_offset,
                                          no_data: out_no_data, last: out_last});
  end

  // Receiver: random stall bursts, plus a long hold-off on request.
  initial begin : result_sink
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_hold > 0) begin
        out_ready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [MR_W-1:0]  limit;
    logic [POS_W-1:0] offset;

    in_valid       <= 1'b0;
    in_command     <= CMD_WRITE;
    in_write_byte  <= '0;
    in_read_offset <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    rst_n          <= 1'b0;
    tracker.reset_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Empty ring: any offset, lowest or highest, is caught up.
    send_item(CMD_READ, 8'h3C, '0);
    send_item(CMD_READ, 8'hC3, '1);
    // Append eight bytes, both byte extremes among them.
    send_item(CMD_WRITE, 8'h00, '1);
    send_item(CMD_WRITE, 8'hFF, '0);
    repeat (6) send_item(CMD_WRITE, 8'($urandom()), POS_W'({$urandom(), $urandom()}));
    send_item(CMD_READ, 8'h00, '0);             // everything written so far
    send_item(CMD_READ, 8'hFF, POS_W'(3));      // start in the middle
    send_item(CMD_READ, 8'h00, POS_W'(7));      // newest byte only
    send_item(CMD_READ, 8'h00, POS_W'(8));      // exactly caught up
    send_item(CMD_READ, 8'h00, {1'b1, 39'h0});  // far ahead of the writer
    // Smallest limit, then a zero limit that must act as one.
    write_max_read(MR_W'(1));
    send_item(CMD_READ, 8'h00, '0);
    write_max_read(MR_W'(0));
    send_item(CMD_READ, 8'h00, POS_W'(2));

    // Random phases, one read limit each; reads mostly land inside the written data.
    for (int p = 0; p <= 5; p++) begin
      limit = (p < 5) ? LIMIT_STEPS[p] : MR_W'($urandom_range(1, 64));
      write_max_read(limit);
      repeat (20) begin
        if ($urandom_range(0, 9) < 6) begin
          send_item(CMD_WRITE, 8'($urandom()), POS_W'({$urandom(), $urandom()}));
        end else begin
          case ($urandom_range(0, 9))
            0, 1: offset = tracker.bytes_written;
            2, 3: offset = POS_W'({$urandom(), $urandom()});
            4: offset = '0;
            default: begin
              offset = tracker.bytes_written - POS_W'($urandom_range(1, 80));
              if (offset > tracker.bytes_written) offset = '0;
            end
          endcase
          send_item(CMD_READ, 8'($urandom()), offset);
        end
      end
    end

    // Back the block up: hold the receiver while full-length reads keep coming.
    write_max_read(MAX_READ_RST);
    sink_hold = LONG_HOLD;
    repeat (6) send_item(CMD_READ, 8'($urandom()), '0);
    // Pause the sender until the backlog is gone.
    drain();

    // Last part, no idling: items back to back on both channels.
    gaps_on = 1'b0;
    repeat (6)
      send_item(CMD_WRITE, 8'($urandom()), POS_W'({$urandom(), $urandom()}));
    send_item(CMD_READ, 8'h00, '0);                                 // capped at the limit
    send_item(CMD_READ, 8'h00, tracker.bytes_written - POS_W'(1));  // newest byte only
    send_item(CMD_READ, 8'h00, tracker.bytes_written);              // exactly caught up
    repeat (15) begin
      if ($urandom_range(0, 2) == 0) begin
        send_item(CMD_WRITE, 8'($urandom()), '0);
      end else begin
        offset = tracker.bytes_written - POS_W'($urandom_range(1, 80));
        if (offset > tracker.bytes_written) offset = '0;
        send_item(CMD_READ, 8'($urandom()), offset);
      end
    end

    drain();
    if (tracker.errors == 0)
      $display("broadcast_byte_ring_buffer regression: pass");
    else
      $display("broadcast_byte_ring_buffer regression: fail");
    $finish;
  end

  // Give up if the run hangs.
  initial begin : watchdog
    #10_000_000;
    $display("broadcast_byte_ring_buffer regression: fail");
    $finish;
  end

endmodule
